// ----- hw/rtl/cmfm_pkg.sv -----
package cmfm_pkg;

  localparam int CHASSIS_MOTORS_DEF = 4;

  localparam int ID_W       = 11;
  localparam int PAYLOAD_W  = 64;
  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int CURRENT_W  = 16;
  localparam int TEMP_W     = 8;
  localparam int TURNS_W    = 32;
  localparam int TURN_LOG2  = 13;
  localparam int UNWRAP_W   = TURNS_W + TURN_LOG2;
  localparam int SLOT_OUT_W = 3;

  localparam int TURN_STEP  = 8000;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_ID       = 1'd1;

  localparam logic [ID_W-1:0] CHASSIS_BASE_RESET = 11'd513;
  localparam logic [ID_W-1:0] YAW_ID_RESET       = 11'd100;

  typedef struct packed {
    logic [ANGLE_W-1:0]   angle;
    logic [SPEED_W-1:0]   speed;
    logic [CURRENT_W-1:0] current;
    logic [TEMP_W-1:0]    temp;
  } frame_fields_t;

  localparam int FIELDS_W = $bits(frame_fields_t);

endpackage

// ----- hw/rtl/can_motor_feedback_multiturn.sv -----
// channel | direction | handshake                | payload
// in      | input     | in_valid / in_ready      | in_std_id, in_payload
// out     | output    | out_valid / out_ready    | slot, decoded fields, turns, unwrapped
// cfg     | input     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one item per cycle unless stalled; a match is queued, then registered onto out
// unmatched ids are dropped at the front and produce nothing
// synchronous reset clears per-slot angle and turn state, ids return to 513 and 100
// in_ready falls only when the two-entry queue before the unwrap stage is full
// cfg_ready is always high
module can_motor_feedback_multiturn #(
  parameter int CHASSIS_MOTORS = cmfm_pkg::CHASSIS_MOTORS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [cmfm_pkg::ID_W-1:0]                in_std_id,
  input  logic [cmfm_pkg::PAYLOAD_W-1:0]           in_payload,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [cmfm_pkg::SLOT_OUT_W-1:0]          out_motor_slot,
  output logic signed [cmfm_pkg::ANGLE_W-1:0]      out_rotor_angle,
  output logic signed [cmfm_pkg::SPEED_W-1:0]     out_rotor_speed,
  output logic signed [cmfm_pkg::CURRENT_W-1:0]   out_torque_current,
  output logic [cmfm_pkg::TEMP_W-1:0]             out_temperature,
  output logic signed [cmfm_pkg::TURNS_W-1:0]     out_turns,
  output logic signed [cmfm_pkg::UNWRAP_W-1:0]    out_unwrapped_angle,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [cmfm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [cmfm_pkg::ID_W-1:0]                cfg_data
);

  localparam int SLOT_W = $clog2(CHASSIS_MOTORS + 1);
  localparam int Q_W    = SLOT_W + cmfm_pkg::FIELDS_W;

  logic                    push_valid;
  logic                    push_ready;
  logic [SLOT_W-1:0]       push_slot;
  cmfm_pkg::frame_fields_t push_fields;
  logic                    q_valid;
  logic                    q_pop;
  logic [Q_W-1:0]          q_data;
  logic [SLOT_W-1:0]       q_slot;
  cmfm_pkg::frame_fields_t q_fields;

  cmfm_front #(
    .CHASSIS_MOTORS(CHASSIS_MOTORS),
    .SLOT_W(SLOT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_std_id  (in_std_id),
    .in_payload (in_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_slot  (push_slot),
    .push_fields(push_fields)
  );

  cmfm_queue #(
    .WIDTH(Q_W),
    .DEPTH(cmfm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data ({push_slot, push_fields}),
    .rd_valid(q_valid),
    .rd_pop  (q_pop),
    .rd_data (q_data)
  );

  assign q_slot   = q_data[Q_W-1:cmfm_pkg::FIELDS_W];
  assign q_fields = q_data[cmfm_pkg::FIELDS_W-1:0];

  cmfm_back #(
    .CHASSIS_MOTORS(CHASSIS_MOTORS),
    .SLOT_W(SLOT_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_slot             (q_slot),
    .q_fields           (q_fields),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_motor_slot     (out_motor_slot),
    .out_rotor_angle    (out_rotor_angle),
    .out_rotor_speed    (out_rotor_speed),
    .out_torque_current (out_torque_current),
    .out_temperature    (out_temperature),
    .out_turns          (out_turns),
    .out_unwrapped_angle(out_unwrapped_angle)
  );

endmodule

// ----- hw/rtl/cmfm_front.sv -----
module cmfm_front #(
  parameter int CHASSIS_MOTORS = cmfm_pkg::CHASSIS_MOTORS_DEF,
  parameter int SLOT_W = $clog2(CHASSIS_MOTORS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cmfm_pkg::ID_W-1:0]           in_std_id,
  input  logic [cmfm_pkg::PAYLOAD_W-1:0]      in_payload,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmfm_pkg::ID_W-1:0]           cfg_data,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [SLOT_W-1:0]                   push_slot,
  output cmfm_pkg::frame_fields_t             push_fields
);

  logic [cmfm_pkg::ID_W-1:0] chassis_base_r, chassis_base_nxt;
  logic [cmfm_pkg::ID_W-1:0] yaw_id_r, yaw_id_nxt;
  logic [cmfm_pkg::ID_W:0]   offset;
  logic                      chassis_hit;
  logic                      yaw_hit;

  assign cfg_ready = 1'b1;

  always_comb begin
    chassis_base_nxt = chassis_base_r;
    yaw_id_nxt       = yaw_id_r;
    if (cfg_valid) begin
      case (cfg_index)
        cmfm_pkg::REG_CHASSIS_BASE: chassis_base_nxt = cfg_data;
        cmfm_pkg::REG_YAW_ID:       yaw_id_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chassis_base_r <= cmfm_pkg::CHASSIS_BASE_RESET;
      yaw_id_r       <= cmfm_pkg::YAW_ID_RESET;
    end else begin
      chassis_base_r <= chassis_base_nxt;
      yaw_id_r       <= yaw_id_nxt;
    end
  end

  // id classification, chassis window wins over yaw
  assign offset = {1'b0, in_std_id} - {1'b0, chassis_base_r};
  assign chassis_hit = !offset[cmfm_pkg::ID_W] &&
                       (offset[cmfm_pkg::ID_W-1:0] < cmfm_pkg::ID_W'(CHASSIS_MOTORS));
  assign yaw_hit = (in_std_id == yaw_id_r);

  always_comb begin
    if (chassis_hit) begin
      push_slot = SLOT_W'(offset[cmfm_pkg::ID_W-1:0]) + SLOT_W'(1);
    end else begin
      push_slot = '0;
    end
  end

  assign push_fields.angle   = in_payload[63:48];
  assign push_fields.speed   = in_payload[47:32];
  assign push_fields.current = in_payload[31:16];
  assign push_fields.temp    = in_payload[15:8];

  assign in_ready   = push_ready;
  assign push_valid = in_valid && (chassis_hit || yaw_hit);

endmodule

// ----- hw/rtl/cmfm_queue.sv -----
module cmfm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cmfm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/cmfm_back.sv -----
module cmfm_back #(
  parameter int CHASSIS_MOTORS = cmfm_pkg::CHASSIS_MOTORS_DEF,
  parameter int SLOT_W = $clog2(CHASSIS_MOTORS + 1)
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  output logic                                     q_pop,
  input  logic [SLOT_W-1:0]                        q_slot,
  input  cmfm_pkg::frame_fields_t                  q_fields,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [cmfm_pkg::SLOT_OUT_W-1:0]          out_motor_slot,
  output logic signed [cmfm_pkg::ANGLE_W-1:0]      out_rotor_angle,
  output logic signed [cmfm_pkg::SPEED_W-1:0]     out_rotor_speed,
  output logic signed [cmfm_pkg::CURRENT_W-1:0]   out_torque_current,
  output logic [cmfm_pkg::TEMP_W-1:0]             out_temperature,
  output logic signed [cmfm_pkg::TURNS_W-1:0]     out_turns,
  output logic signed [cmfm_pkg::UNWRAP_W-1:0]    out_unwrapped_angle
);

  localparam int SLOTS = CHASSIS_MOTORS + 1;
  localparam int AW    = cmfm_pkg::ANGLE_W;
  localparam int TW    = cmfm_pkg::TURNS_W;
  localparam int TL    = cmfm_pkg::TURN_LOG2;
  localparam logic signed [AW:0] STEP_POS = (AW + 1)'(cmfm_pkg::TURN_STEP);
  localparam logic signed [AW:0] STEP_NEG = -STEP_POS;

  logic [AW-1:0]        prev_angle_r [SLOTS];
  logic [TW-1:0]        turn_count_r [SLOTS];
  logic                 out_valid_r, out_valid_nxt;
  logic [cmfm_pkg::SLOT_OUT_W-1:0] slot_r;
  cmfm_pkg::frame_fields_t         fields_r;
  logic [TW-1:0]        turns_r;
  logic [TW-1:0]        unwrap_hi_r;

  logic [AW-1:0]        angle;
  logic [AW-1:0]        prev;
  logic signed [AW:0]   step;
  logic [TW-1:0]        turn_nxt;
  logic [TW-1:0]        unwrap_hi;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign angle = q_fields.angle;
  assign prev  = prev_angle_r[q_slot];
  assign step  = $signed({angle[AW-1], angle}) - $signed({prev[AW-1], prev});

  always_comb begin
    turn_nxt = turn_count_r[q_slot];
    if (step < STEP_NEG) begin
      turn_nxt = turn_count_r[q_slot] + TW'(1);
    end else if (step > STEP_POS) begin
      turn_nxt = turn_count_r[q_slot] - TW'(1);
    end
  end

  // upper part of angle + turns * 8192: low bits pass straight through
  assign unwrap_hi = turn_nxt + {{(TW - AW + TL){angle[AW-1]}}, angle[AW-1:TL]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        prev_angle_r[i] <= '0;
        turn_count_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        prev_angle_r[q_slot] <= angle;
        turn_count_r[q_slot] <= turn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot_r      <= cmfm_pkg::SLOT_OUT_W'(q_slot);
      fields_r    <= q_fields;
      turns_r     <= turn_nxt;
      unwrap_hi_r <= unwrap_hi;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_slot      = slot_r;
  assign out_rotor_angle     = fields_r.angle;
  assign out_rotor_speed     = fields_r.speed;
  assign out_torque_current  = fields_r.current;
  assign out_temperature     = fields_r.temp;
  assign out_turns           = turns_r;
  assign out_unwrapped_angle = {unwrap_hi_r, fields_r.angle[TL-1:0]};

endmodule

// ----- hw/rtl/cmfm_checker.sv -----
module cmfm_checker #(
  parameter int CHASSIS_MOTORS = cmfm_pkg::CHASSIS_MOTORS_DEF
) (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic [cmfm_pkg::SLOT_OUT_W-1:0]          out_motor_slot,
  input logic signed [cmfm_pkg::ANGLE_W-1:0]      out_rotor_angle,
  input logic signed [cmfm_pkg::TURNS_W-1:0]      out_turns,
  input logic signed [cmfm_pkg::UNWRAP_W-1:0]     out_unwrapped_angle
);

  localparam int TL = cmfm_pkg::TURN_LOG2;
  localparam int AW = cmfm_pkg::ANGLE_W;
  localparam int TW = cmfm_pkg::TURNS_W;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unwrapped_angle)
      && $stable(out_turns))
    else $error("stalled item changed");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (CHASSIS_MOTORS < 8) |-> out_motor_slot <= cmfm_pkg::SLOT_OUT_W'(CHASSIS_MOTORS))
    else $error("slot out of range");

  a_unwrap_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unwrapped_angle[TL-1:0] == out_rotor_angle[TL-1:0])
    else $error("unwrapped angle low bits differ from angle");

  a_unwrap_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unwrapped_angle[TW+TL-1:TL] ==
      TW'(out_turns + {{(TW - AW + TL){out_rotor_angle[AW-1]}}, out_rotor_angle[AW-1:TL]}))
    else $error("unwrapped angle does not match turns");

endmodule

bind can_motor_feedback_multiturn cmfm_checker #(
  .CHASSIS_MOTORS(CHASSIS_MOTORS)
) u_cmfm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_motor_slot     (out_motor_slot),
  .out_rotor_angle    (out_rotor_angle),
  .out_turns          (out_turns),
  .out_unwrapped_angle(out_unwrapped_angle)
);
